// ----- hdl/kce_pkg.sv -----
// Shared types and constants of the k-means clustering engine.
package kce_pkg;

	localparam int COORD_W = 16;
	localparam int NUM_COORDS = 4;
	localparam int NF_W = 3;
	localparam int DIST_W = 2 * COORD_W + 2;
	localparam int ROOT_W = DIST_W / 2;

	typedef logic [NUM_COORDS-1:0][COORD_W-1:0] coord_vec_t;

	typedef enum logic [1:0] {
		REQ_SEED  = 2'd0,
		REQ_POINT = 2'd1,
		REQ_RUN   = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_NUM_CLUSTERS   = 2'd0,
		REG_NUM_FEATURES   = 2'd1,
		REG_MOVE_THRESHOLD = 2'd2,
		REG_MAX_ITERATIONS = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_LAT,
		S_A_DIST,
		S_A_CMP,
		S_U_INIT,
		S_U_RD,
		S_U_ACC,
		S_U_DIV,
		S_U_DWAIT,
		S_U_MOVE,
		S_U_SQ,
		S_U_SQW,
		S_CHECK,
		S_O_RD,
		S_O_EMIT
	} state_t;

	typedef struct packed {
		logic pt_lat;
		logic acc_clr;
		logic acc_add;
		logic move_mode;
		logic best_upd;
		logic asg_we;
		logic sum_clr;
		logic sum_acc;
		logic div_start;
		logic div_take;
		logic sqrt_start;
		logic cum_clr;
		logic cen_upd;
		logic out_sel;
		logic emit;
		logic emit_last;
		logic run_end;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic cnt_zero;
		logic cum_below;
	} stat_t;

endpackage

// ----- hdl/kce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/kce_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module kce_div #(
	parameter int DVD_W = 23,
	parameter int DVS_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- hdl/kce_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module kce_sqrt #(
	parameter int IN_W = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   x,
	output logic              done,
	output logic [IN_W/2-1:0] root
);

	logic            busy_q;
	logic            done_q;
	logic [IN_W-1:0] x_q;
	logic [IN_W-1:0] r_q;
	logic [IN_W-1:0] b_q;
	logic [IN_W:0]   trial;
	logic            ge;

	assign trial = {1'b0, r_q} + {1'b0, b_q};
	assign ge = {1'b0, x_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && b_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			r_q <= '0;
			b_q <= IN_W'(1) << (IN_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q <= IN_W'({1'b0, x_q} - trial);
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[IN_W/2-1:0];

endmodule

// ----- hdl/kce_dp.sv -----
// Datapath: stores, distance unit, accumulators, divider, square root and result registers.
module kce_dp #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_CLUSTERS = 8,
	parameter int MAX_FEATURES = 4,
	localparam int PID_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int PC_W = $clog2(MAX_POINTS + 1),
	localparam int CID_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
	localparam int KC_W = $clog2(MAX_CLUSTERS + 1),
	localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_seed,
	input  logic                load_point,
	input  kce_pkg::coord_vec_t coords,
	input  logic [KC_W-1:0]     k,
	input  logic [2:0]          nf,
	input  logic [15:0]         thr,
	input  kce_pkg::cmd_t       cmd,
	input  logic [PID_W-1:0]    p_idx,
	input  logic [CID_W-1:0]    c_idx,
	input  logic [FI_W-1:0]     f_idx,
	input  logic [7:0]          passes,
	input  logic                conv,
	output logic [PC_W-1:0]     n,
	output kce_pkg::stat_t      status,
	output logic                res_valid,
	output logic [5:0]          res_point,
	output logic [2:0]          res_cluster,
	output kce_pkg::coord_vec_t res_cen,
	output logic [7:0]          res_passes,
	output logic                res_conv,
	output logic                res_last
);
	import kce_pkg::*;

	localparam int SUM_W = COORD_W + $clog2(MAX_POINTS);
	localparam int DVD_W = SUM_W + 1;
	localparam int CUM_W = ROOT_W + KC_W;
	localparam int TK_W = 16 + KC_W;

	logic [PC_W-1:0] pcnt_q;
	logic [KC_W-1:0] scnt_q;

	logic [MAX_FEATURES-1:0][COORD_W-1:0] pt_rdata;
	logic [MAX_FEATURES-1:0][COORD_W-1:0] pt_q;
	logic [CID_W-1:0]                     asg_rdata;
	logic [CID_W-1:0]                     asg_wdata;

	logic [COORD_W-1:0]      cen_q [MAX_CLUSTERS][MAX_FEATURES];
	logic [COORD_W-1:0]      newc_q [MAX_FEATURES];
	logic signed [SUM_W-1:0] sum_q [MAX_FEATURES];
	logic [PC_W-1:0]         cnt_q;
	logic [DIST_W-1:0]       acc_q;
	logic [DIST_W-1:0]       best_q;
	logic [CID_W-1:0]        best_id_q;
	logic [CUM_W-1:0]        cum_q;

	logic [CID_W-1:0]         cen_idx;
	logic [COORD_W-1:0]       opa;
	logic [COORD_W-1:0]       opb;
	logic signed [COORD_W:0]  diff;
	logic signed [DIST_W-1:0] sq;
	logic                     take_new;
	logic [SUM_W-1:0]         sum_f;
	logic [SUM_W-1:0]         mag;
	logic [DVD_W-1:0]         dividend;
	logic [DVD_W-1:0]         quot;
	logic [COORD_W-1:0]       q16;
	logic [ROOT_W-1:0]        root;
	logic [TK_W-1:0]          thr_k;

	kce_ram #(.WIDTH(MAX_FEATURES * COORD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (load_point && (pcnt_q < PC_W'(MAX_POINTS))),
		.waddr (pcnt_q[PID_W-1:0]),
		.wdata (coords[MAX_FEATURES-1:0]),
		.raddr (p_idx),
		.rdata (pt_rdata)
	);

	kce_ram #(.WIDTH(CID_W), .DEPTH(MAX_POINTS)) u_asg_ram (
		.clk   (clk),
		.we    (cmd.asg_we),
		.waddr (p_idx),
		.wdata (asg_wdata),
		.raddr (p_idx),
		.rdata (asg_rdata)
	);

	assign cen_idx = cmd.out_sel ? asg_rdata : c_idx;
	assign opa = cmd.move_mode ? newc_q[f_idx] : pt_q[f_idx];
	assign opb = cen_q[cen_idx][f_idx];
	assign diff = $signed({opa[COORD_W-1], opa}) - $signed({opb[COORD_W-1], opb});
	assign sq = diff * diff;

	assign take_new = (c_idx == '0) || (acc_q < best_q);
	assign asg_wdata = take_new ? c_idx : best_id_q;

	assign sum_f = sum_q[f_idx];
	assign mag = sum_f[SUM_W-1] ? (~sum_f + SUM_W'(1)) : sum_f;
	assign dividend = DVD_W'(mag) + DVD_W'(cnt_q >> 1);
	assign q16 = quot[COORD_W-1:0];
	assign thr_k = TK_W'(thr) * TK_W'(k);

	kce_div #(.DVD_W(DVD_W), .DVS_W(PC_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (cnt_q),
		.done     (status.div_done),
		.quot     (quot)
	);

	kce_sqrt #(.IN_W(DIST_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.x      (acc_q),
		.done   (status.sqrt_done),
		.root   (root)
	);

	assign status.cnt_zero = (cnt_q == '0);
	assign status.cum_below = cum_q < CUM_W'(thr_k);
	assign n = pcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q    <= '0;
			scnt_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= cmd.emit;
			if (cmd.run_end) begin
				pcnt_q <= '0;
				scnt_q <= '0;
			end else begin
				if (load_point && (pcnt_q < PC_W'(MAX_POINTS))) begin
					pcnt_q <= pcnt_q + PC_W'(1);
				end
				if (load_seed && (scnt_q < KC_W'(MAX_CLUSTERS))) begin
					scnt_q <= scnt_q + KC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_seed && (scnt_q < KC_W'(MAX_CLUSTERS))) begin
			for (int f = 0; f < MAX_FEATURES; f++) begin
				cen_q[scnt_q[CID_W-1:0]][f] <= coords[f];
			end
		end else if (cmd.cen_upd) begin
			for (int f = 0; f < MAX_FEATURES; f++) begin
				if (f < int'(nf)) begin
					cen_q[c_idx][f] <= newc_q[f];
				end
			end
		end
		if (cmd.pt_lat) begin
			pt_q <= pt_rdata;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + DIST_W'($unsigned(sq));
		end
		if (cmd.best_upd && take_new) begin
			best_q    <= acc_q;
			best_id_q <= c_idx;
		end
		if (cmd.sum_clr) begin
			cnt_q <= '0;
			for (int f = 0; f < MAX_FEATURES; f++) begin
				sum_q[f] <= '0;
			end
		end else if (cmd.sum_acc && (asg_rdata == c_idx)) begin
			cnt_q <= cnt_q + PC_W'(1);
			for (int f = 0; f < MAX_FEATURES; f++) begin
				sum_q[f] <= sum_q[f] + SUM_W'($signed(pt_rdata[f]));
			end
		end
		if (cmd.div_take) begin
			newc_q[f_idx] <= sum_f[SUM_W-1] ? (~q16 + COORD_W'(1)) : q16;
		end
		if (cmd.cum_clr) begin
			cum_q <= '0;
		end else if (cmd.cen_upd) begin
			cum_q <= cum_q + CUM_W'(root);
		end
		if (cmd.emit) begin
			res_point   <= 6'(p_idx);
			res_cluster <= 3'(asg_rdata);
			res_passes  <= passes;
			res_conv    <= conv;
			res_last    <= cmd.emit_last;
			for (int f = 0; f < NUM_COORDS; f++) begin
				if ((f < MAX_FEATURES) && (f < int'(nf))) begin
					res_cen[f] <= cen_q[cen_idx][f];
				end else begin
					res_cen[f] <= '0;
				end
			end
		end
	end

endmodule

// ----- hdl/kce_ctrl.sv -----
// Controller: sequences assignment, centroid update, convergence check and result output.
module kce_ctrl #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_CLUSTERS = 8,
	parameter int MAX_FEATURES = 4,
	localparam int PID_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int PC_W = $clog2(MAX_POINTS + 1),
	localparam int CID_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
	localparam int KC_W = $clog2(MAX_CLUSTERS + 1),
	localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             run_req,
	input  logic [PC_W-1:0]  n,
	input  logic [KC_W-1:0]  k,
	input  logic [2:0]       nf,
	input  logic [7:0]       lim,
	input  kce_pkg::stat_t   status,
	output kce_pkg::cmd_t    cmd,
	output logic             busy,
	output logic [PID_W-1:0] p_idx,
	output logic [CID_W-1:0] c_idx,
	output logic [FI_W-1:0]  f_idx,
	output logic [7:0]       passes,
	output logic             conv
);
	import kce_pkg::*;

	state_t           state_q, state_d;
	logic [PID_W-1:0] p_q, p_d;
	logic [CID_W-1:0] c_q, c_d;
	logic [FI_W-1:0]  f_q, f_d;
	logic [7:0]       passes_q, passes_d;
	logic             conv_q, conv_d;
	logic             post_q, post_d;
	logic             p_last, c_last, f_last;

	assign p_last = (PC_W'(p_q) + PC_W'(1)) == n;
	assign c_last = (KC_W'(c_q) + KC_W'(1)) == k;
	assign f_last = (NF_W'(f_q) + NF_W'(1)) == nf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			p_q      <= '0;
			c_q      <= '0;
			f_q      <= '0;
			passes_q <= '0;
			conv_q   <= 1'b0;
			post_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			p_q      <= p_d;
			c_q      <= c_d;
			f_q      <= f_d;
			passes_q <= passes_d;
			conv_q   <= conv_d;
			post_q   <= post_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		p_d      = p_q;
		c_d      = c_q;
		f_d      = f_q;
		passes_d = passes_q;
		conv_d   = conv_q;
		post_d   = post_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (run_req && (n != '0)) begin
					p_d      = '0;
					post_d   = 1'b0;
					passes_d = '0;
					conv_d   = 1'b0;
					state_d  = S_A_RD;
				end
			end
			S_A_RD: begin
				state_d = S_A_LAT;
			end
			S_A_LAT: begin
				cmd.pt_lat  = 1'b1;
				cmd.acc_clr = 1'b1;
				c_d         = '0;
				f_d         = '0;
				state_d     = S_A_DIST;
			end
			S_A_DIST: begin
				cmd.acc_add = 1'b1;
				f_d         = f_q + FI_W'(1);
				if (f_last) begin
					state_d = S_A_CMP;
				end
			end
			S_A_CMP: begin
				cmd.best_upd = 1'b1;
				if (c_last) begin
					cmd.asg_we = 1'b1;
					if (!p_last) begin
						p_d     = p_q + PID_W'(1);
						state_d = S_A_RD;
					end else if (post_q) begin
						state_d = S_CHECK;
					end else begin
						post_d      = 1'b1;
						c_d         = '0;
						cmd.cum_clr = 1'b1;
						state_d     = S_U_INIT;
					end
				end else begin
					c_d         = c_q + CID_W'(1);
					f_d         = '0;
					cmd.acc_clr = 1'b1;
					state_d     = S_A_DIST;
				end
			end
			S_U_INIT: begin
				cmd.sum_clr = 1'b1;
				p_d         = '0;
				state_d     = S_U_RD;
			end
			S_U_RD: begin
				state_d = S_U_ACC;
			end
			S_U_ACC: begin
				cmd.sum_acc = 1'b1;
				if (p_last) begin
					f_d     = '0;
					state_d = S_U_DIV;
				end else begin
					p_d     = p_q + PID_W'(1);
					state_d = S_U_RD;
				end
			end
			S_U_DIV: begin
				if (status.cnt_zero) begin
					if (c_last) begin
						p_d     = '0;
						state_d = S_A_RD;
					end else begin
						c_d     = c_q + CID_W'(1);
						state_d = S_U_INIT;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_U_DWAIT;
				end
			end
			S_U_DWAIT: begin
				if (status.div_done) begin
					cmd.div_take = 1'b1;
					if (f_last) begin
						f_d         = '0;
						cmd.acc_clr = 1'b1;
						state_d     = S_U_MOVE;
					end else begin
						f_d     = f_q + FI_W'(1);
						state_d = S_U_DIV;
					end
				end
			end
			S_U_MOVE: begin
				cmd.acc_add   = 1'b1;
				cmd.move_mode = 1'b1;
				f_d           = f_q + FI_W'(1);
				if (f_last) begin
					state_d = S_U_SQ;
				end
			end
			S_U_SQ: begin
				cmd.sqrt_start = 1'b1;
				state_d        = S_U_SQW;
			end
			S_U_SQW: begin
				if (status.sqrt_done) begin
					cmd.cen_upd = 1'b1;
					if (c_last) begin
						p_d     = '0;
						state_d = S_A_RD;
					end else begin
						c_d     = c_q + CID_W'(1);
						state_d = S_U_INIT;
					end
				end
			end
			S_CHECK: begin
				passes_d = passes_q + 8'd1;
				p_d      = '0;
				if (status.cum_below) begin
					conv_d  = 1'b1;
					state_d = S_O_RD;
				end else if ((passes_q + 8'd1) >= lim) begin
					state_d = S_O_RD;
				end else begin
					c_d         = '0;
					cmd.cum_clr = 1'b1;
					state_d     = S_U_INIT;
				end
			end
			S_O_RD: begin
				state_d = S_O_EMIT;
			end
			S_O_EMIT: begin
				cmd.out_sel   = 1'b1;
				cmd.emit      = 1'b1;
				cmd.emit_last = p_last;
				if (p_last) begin
					cmd.run_end = 1'b1;
					state_d     = S_IDLE;
				end else begin
					p_d     = p_q + PID_W'(1);
					state_d = S_O_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign p_idx  = p_q;
	assign c_idx  = c_q;
	assign f_idx  = f_q;
	assign passes = passes_q;
	assign conv   = conv_q;

`ifndef SYNTHESIS
	a_run_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (n != '0))
		else $error("run in progress with an empty point store");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_O_EMIT) |-> (PC_W'(p_q) < n))
		else $error("result emitted for a point that was never loaded");
	a_check_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (passes_q < lim))
		else $error("refinement pass count ran past the limit");
	a_div_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_U_DWAIT) && !status.div_done) |=> (state_q == S_U_DWAIT))
		else $error("left divider wait without a finished quotient");
`endif

endmodule

// ----- hdl/kmeans_clustering_engine.sv -----
// Top level of the k-means clustering engine: configuration registers and unit wiring.
// Seed and point loads can follow back to back; busy stays low.
// A run makes an assignment sweep and then refinement passes; each pass sums the points of
// every cluster, runs the iterative divider and square root per nonempty cluster and makes
// another assignment sweep, and the run then delivers one result per loaded point.
// Results are single-cycle strobes; asynchronous reset restores the register defaults and
// empties the load counters, while point, centroid and assignment stores keep their contents.
module kmeans_clustering_engine #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_CLUSTERS = 8,
	parameter int MAX_FEATURES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] coord_0,
	input  logic signed [15:0] coord_1,
	input  logic signed [15:0] coord_2,
	input  logic signed [15:0] coord_3,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic               result_valid,
	output logic [5:0]         point_index,
	output logic [2:0]         cluster_id,
	output logic signed [15:0] centroid_0,
	output logic signed [15:0] centroid_1,
	output logic signed [15:0] centroid_2,
	output logic signed [15:0] centroid_3,
	output logic [7:0]         passes_used,
	output logic               converged,
	output logic               last_result
);
	import kce_pkg::*;

	localparam int PID_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PC_W = $clog2(MAX_POINTS + 1);
	localparam int CID_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int KC_W = $clog2(MAX_CLUSTERS + 1);
	localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

	logic [3:0]  num_clusters_q;
	logic [2:0]  num_features_q;
	logic [15:0] move_threshold_q;
	logic [7:0]  max_iterations_q;

	logic             accept;
	logic [KC_W-1:0]  k_eff;
	logic [2:0]       nf_eff;
	logic [7:0]       lim_eff;
	cmd_t             cmd;
	stat_t            status;
	logic [PID_W-1:0] p_idx;
	logic [CID_W-1:0] c_idx;
	logic [FI_W-1:0]  f_idx;
	logic [7:0]       passes;
	logic             conv;
	logic [PC_W-1:0]  n;
	coord_vec_t       coords;
	coord_vec_t       res_cen;
	cfg_reg_t         wsel;
	cfg_reg_t         rsel;

	assign accept = start && !busy;
	assign coords = {coord_3, coord_2, coord_1, coord_0};
	assign wsel = cfg_reg_t'(paddr[3:2]);
	assign rsel = cfg_reg_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q   <= 4'd3;
			num_features_q   <= 3'd2;
			move_threshold_q <= 16'd3;
			max_iterations_q <= 8'd64;
		end else if (psel && penable && pwrite && pready) begin
			unique case (wsel)
				REG_NUM_CLUSTERS:   num_clusters_q   <= pwdata[3:0];
				REG_NUM_FEATURES:   num_features_q   <= pwdata[2:0];
				REG_MOVE_THRESHOLD: move_threshold_q <= pwdata[15:0];
				REG_MAX_ITERATIONS: max_iterations_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (rsel)
			REG_NUM_CLUSTERS:   prdata = 32'(num_clusters_q);
			REG_NUM_FEATURES:   prdata = 32'(num_features_q);
			REG_MOVE_THRESHOLD: prdata = 32'(move_threshold_q);
			REG_MAX_ITERATIONS: prdata = 32'(max_iterations_q);
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		if (num_clusters_q == 4'd0) begin
			k_eff = KC_W'(1);
		end else if (32'(num_clusters_q) > MAX_CLUSTERS) begin
			k_eff = KC_W'(MAX_CLUSTERS);
		end else begin
			k_eff = KC_W'(num_clusters_q);
		end
		if (num_features_q == 3'd0) begin
			nf_eff = 3'd1;
		end else if (32'(num_features_q) > MAX_FEATURES) begin
			nf_eff = 3'(MAX_FEATURES);
		end else begin
			nf_eff = num_features_q;
		end
		lim_eff = (max_iterations_q == 8'd0) ? 8'd1 : max_iterations_q;
	end

	kce_ctrl #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_FEATURES (MAX_FEATURES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.run_req (accept && (req_type == REQ_RUN)),
		.n       (n),
		.k       (k_eff),
		.nf      (nf_eff),
		.lim     (lim_eff),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy),
		.p_idx   (p_idx),
		.c_idx   (c_idx),
		.f_idx   (f_idx),
		.passes  (passes),
		.conv    (conv)
	);

	kce_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_FEATURES (MAX_FEATURES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_seed   (accept && (req_type == REQ_SEED)),
		.load_point  (accept && (req_type == REQ_POINT)),
		.coords      (coords),
		.k           (k_eff),
		.nf          (nf_eff),
		.thr         (move_threshold_q),
		.cmd         (cmd),
		.p_idx       (p_idx),
		.c_idx       (c_idx),
		.f_idx       (f_idx),
		.passes      (passes),
		.conv        (conv),
		.n           (n),
		.status      (status),
		.res_valid   (result_valid),
		.res_point   (point_index),
		.res_cluster (cluster_id),
		.res_cen     (res_cen),
		.res_passes  (passes_used),
		.res_conv    (converged),
		.res_last    (last_result)
	);

	assign centroid_0 = res_cen[0];
	assign centroid_1 = res_cen[1];
	assign centroid_2 = res_cen[2];
	assign centroid_3 = res_cen[3];

endmodule

// ----- test/tb_kmeans_clustering_engine.sv -----
// Self-checking testbench for the k-means clustering engine with its own clustering predictor.
`timescale 1ns / 1ps

module tb_kmeans_clustering_engine;
	import kce_pkg::*;

	typedef struct packed {
		req_t req;
		logic signed [15:0] c0, c1, c2, c3;
	} cmd_item_t;

	typedef struct packed {
		logic [5:0] idx;
		logic [2:0] cid;
		logic signed [15:0] m0, m1, m2, m3;
		logic [7:0] passes;
		logic conv;
		logic last;
	} assign_res_t;

	logic clk, arst_n, start, busy;
	logic [1:0] req_type;
	logic signed [15:0] coord_0, coord_1, coord_2, coord_3;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic result_valid;
	logic [5:0] point_index;
	logic [2:0] cluster_id;
	logic signed [15:0] centroid_0, centroid_1, centroid_2, centroid_3;
	logic [7:0] passes_used;
	logic converged, last_result;

	kmeans_clustering_engine DUT (.*);

	cmd_item_t pending_cmds[$];
	assign_res_t expected_assigns[$];
	int mismatches, unexpected, idle_left, runs_done, results_seen;
	bit quiet_mode, hold_for_drain, driver_quiet;

	logic [3:0] k_reg;
	logic [2:0] nf_reg;
	logic [15:0] thr_reg;
	logic [7:0] iter_reg;
	longint pts[64][4];
	longint cents[8][4];
	int asg[64];
	int n_pts, n_seeds;

	function automatic longint sq_dist(longint a[4], longint b[4], int nf);
		longint s = 0;
		for (int f = 0; f < nf; f++) s += (a[f] - b[f]) * (a[f] - b[f]);
		return s;
	endfunction

	function automatic longint int_root(longint x);
		longint r = 0;
		while ((r + 1) * (r + 1) <= x) begin
			r = r + 1;
			if (r > 1000000) begin
				r = longint'($sqrt(real'(x)));
				while (r * r > x) r--;
				while ((r + 1) * (r + 1) <= x) r++;
				return r;
			end
		end
		return r;
	endfunction

	function automatic longint mean_rounded(longint s, longint n);
		longint m = (s < 0) ? -s : s;
		longint q = (m + n / 2) / n;
		return (s < 0) ? -q : q;
	endfunction

	task automatic nearest_all(int k, int nf);
		longint d, bd;
		for (int p = 0; p < n_pts; p++) begin
			asg[p] = 0;
			bd = sq_dist(pts[p], cents[0], nf);
			for (int c = 1; c < k; c++) begin
				d = sq_dist(pts[p], cents[c], nf);
				if (d < bd) begin
					bd = d;
					asg[p] = c;
				end
			end
		end
	endtask

	task automatic predict_clustering(cmd_item_t it);
		int k, nf, lim, passes, cnt;
		bit conv;
		longint cum, sum[4], old[4];
		assign_res_t r;
		case (it.req)
			REQ_SEED: begin
				if (n_seeds < 8) begin
					cents[n_seeds] = '{it.c0, it.c1, it.c2, it.c3};
					n_seeds++;
				end
			end
			REQ_POINT: begin
				if (n_pts < 64) begin
					pts[n_pts] = '{it.c0, it.c1, it.c2, it.c3};
					n_pts++;
				end
			end
			REQ_RUN: begin
				if (n_pts != 0) begin
					k = (k_reg == 0) ? 1 : (k_reg > 8) ? 8 : k_reg;
					nf = (nf_reg == 0) ? 1 : (nf_reg > 4) ? 4 : nf_reg;
					lim = (iter_reg == 0) ? 1 : iter_reg;
					passes = 0;
					conv = 0;
					nearest_all(k, nf);
					forever begin
						cum = 0;
						for (int c = 0; c < k; c++) begin
							cnt = 0;
							sum = '{0, 0, 0, 0};
							for (int p = 0; p < n_pts; p++)
								if (asg[p] == c) begin
									cnt++;
									for (int f = 0; f < nf; f++) sum[f] += pts[p][f];
								end
							if (cnt != 0) begin
								old = cents[c];
								for (int f = 0; f < nf; f++) cents[c][f] = mean_rounded(sum[f], cnt);
								cum += int_root(sq_dist(old, cents[c], nf));
							end
						end
						nearest_all(k, nf);
						passes++;
						if (cum < longint'(thr_reg) * k) begin
							conv = 1;
							break;
						end
						if (passes >= lim) break;
					end
					for (int p = 0; p < n_pts; p++) begin
						r.idx = 6'(p);
						r.cid = 3'(asg[p]);
						r.m0 = 16'(cents[asg[p]][0]);
						r.m1 = (nf > 1) ? 16'(cents[asg[p]][1]) : '0;
						r.m2 = (nf > 2) ? 16'(cents[asg[p]][2]) : '0;
						r.m3 = (nf > 3) ? 16'(cents[asg[p]][3]) : '0;
						r.passes = 8'(passes);
						r.conv = conv;
						r.last = (p + 1 == n_pts);
						expected_assigns.insert(expected_assigns.size(), r);
					end
					n_pts = 0;
					n_seeds = 0;
					runs_done++;
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic bit can_send();
		return pending_cmds.size() != 0 && !driver_quiet &&
			!(hold_for_drain && expected_assigns.size() != 0);
	endfunction

	task automatic send_next();
		cmd_item_t it = pending_cmds.pop_front();
		start <= 1;
		req_type <= it.req;
		coord_0 <= it.c0;
		coord_1 <= it.c1;
		coord_2 <= it.c2;
		coord_3 <= it.c3;
	endtask

	// Driver: one command per transfer, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			idle_left = 0;
		end else if (start && !busy) begin
			predict_clustering(cmd_item_t'({req_t'(req_type), coord_0, coord_1, coord_2, coord_3}));
			idle_left = (!quiet_mode && $urandom_range(3) == 0) ? $urandom_range(1, 17) : 0;
			if (idle_left == 0 && can_send())
				send_next();
			else
				start <= 0;
		end else if (!start) begin
			if (idle_left > 0) idle_left--;
			else if (can_send()) send_next();
		end
	end

	// Monitor: compare each result strobe with the oldest prediction.
	always @(posedge clk) begin
		assign_res_t exp_r, got;
		if (arst_n && result_valid) begin
			got = {point_index, cluster_id, centroid_0, centroid_1, centroid_2, centroid_3,
				passes_used, converged, last_result};
			results_seen++;
			if (expected_assigns.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10) $display("Unexpected result %p", got);
			end else begin
				exp_r = expected_assigns.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("Mismatch: expected %p, got %p", exp_r, got);
				end
			end
		end
	end

	task automatic reg_write(cfg_reg_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_NUM_CLUSTERS: k_reg = v[3:0];
			REG_NUM_FEATURES: nf_reg = v[2:0];
			REG_MOVE_THRESHOLD: thr_reg = v[15:0];
			default: iter_reg = v[7:0];
		endcase
	endtask

	task automatic add_cmd(req_t r, logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d);
		pending_cmds.insert(pending_cmds.size(), cmd_item_t'{r, a, b, c, d});
	endtask

	function automatic logic [15:0] rnd_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_cmds.size() != 0 || start || busy || expected_assigns.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_batch(int seeds, int points, bit extra_noise);
		for (int s = 0; s < seeds; s++)
			add_cmd(REQ_SEED, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
		for (int p = 0; p < points; p++) begin
			add_cmd(REQ_POINT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
			if (extra_noise && $urandom_range(7) == 0)
				add_cmd(REQ_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
		end
		add_cmd(REQ_RUN, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		req_type = REQ_NONE;
		{coord_0, coord_1, coord_2, coord_3} = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		k_reg = 3;
		nf_reg = 2;
		thr_reg = 3;
		iter_reg = 64;
		n_pts = 0;
		n_seeds = 0;
		hold_for_drain = 0;
		quiet_mode = 0;
		driver_quiet = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, ignored request, empty run, ties at reset settings.
		add_cmd(REQ_RUN, 0, 0, 0, 0);
		add_cmd(REQ_SEED, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_cmd(REQ_SEED, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		add_cmd(REQ_SEED, 0, 0, 0, 0);
		add_cmd(REQ_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add_cmd(REQ_POINT, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
		add_cmd(REQ_POINT, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
		add_cmd(REQ_POINT, 16'h0100, 16'hff00, 0, 0);
		add_cmd(REQ_POINT, 0, 0, 16'h1234, 16'h5678);
		add_cmd(REQ_RUN, 0, 0, 0, 0);
		wait_idle();

		// More than the allowed seeds with an extreme configuration, then a pause to drain.
		reg_write(REG_NUM_CLUSTERS, 15);
		reg_write(REG_NUM_FEATURES, 7);
		reg_write(REG_MOVE_THRESHOLD, 0);
		reg_write(REG_MAX_ITERATIONS, 0);
		random_batch(10, 4, 0);
		wait_idle();

		reg_write(REG_NUM_CLUSTERS, 0);
		reg_write(REG_NUM_FEATURES, 0);
		reg_write(REG_MOVE_THRESHOLD, 16'hffff);
		reg_write(REG_MAX_ITERATIONS, 255);
		random_batch(0, 5, 1);
		hold_for_drain = 1;
		wait_idle();
		hold_for_drain = 0;

		reg_write(REG_NUM_CLUSTERS, 8);
		reg_write(REG_NUM_FEATURES, 4);
		reg_write(REG_MOVE_THRESHOLD, 1);
		reg_write(REG_MAX_ITERATIONS, 6);
		random_batch(8, 64, 0);
		add_cmd(REQ_POINT, 1, 1, 1, 1);
		wait_idle();

		for (int ph = 0; ph < 2; ph++) begin
			reg_write(REG_NUM_CLUSTERS, $urandom_range(1, 8));
			reg_write(REG_NUM_FEATURES, $urandom_range(1, 4));
			reg_write(REG_MOVE_THRESHOLD, $urandom_range(0, 600));
			reg_write(REG_MAX_ITERATIONS, $urandom_range(1, 12));
			if (ph == 1) quiet_mode = 1;
			random_batch(2, $urandom_range(2, 4), ph < 1);
			wait_idle();
		end

		$display("Covered %0d clustering runs with %0d results across register extremes,",
			runs_done, results_seen);
		$display("seed overflow, ignored requests and an empty run.");
		if (mismatches == 0 && unexpected == 0 && expected_assigns.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2s;
		$display("FAIL");
		$finish;
	end

endmodule
